// ----- hw/rtl/image_correlation_replicate_border_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion helpers for the 3x3 border-replicating correlator
// Both forms sample on clk and stay quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef IMAGE_CORRELATION_REPLICATE_BORDER_ASSERT_SVH
`define IMAGE_CORRELATION_REPLICATE_BORDER_ASSERT_SVH

// Same-cycle implication.
`define ICRB_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("icrb assertion failed");

// Next-cycle implication.
`define ICRB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("icrb assertion failed");

`endif

// ----- hw/rtl/icrb_pkg.sv -----
// ----------------------------------------------------------------------------
// icrb_pkg
// Shared constants, register codes and structs of the 3x3 correlator.
// ----------------------------------------------------------------------------
package icrb_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int KERNEL_SIZE   = 3;
	localparam int NTAPS         = KERNEL_SIZE * KERNEL_SIZE;
	localparam int PIX_W         = 32;
	localparam int HEIGHT_W      = 16;
	localparam int ROW_W         = HEIGHT_W + 1;
	localparam int BPP_W         = 3;
	localparam int CH_W          = 2;
	localparam int TAP_W         = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 64;
	localparam int IMG_W_BITS    = 13;
	localparam int PROD_W        = 25;
	localparam int SUM_W         = 30;
	localparam int QDEPTH        = 4;
	localparam int QADDR_W       = 2;
	localparam int QCNT_W        = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH       = 3'd0,
		REG_HEIGHT      = 3'd1,
		REG_BPP         = 3'd2,
		REG_CHSEL       = 3'd3,
		REG_COEF_FIRST  = 3'd4,
		REG_COEF_SECOND = 3'd5,
		REG_COEF_LAST   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0]           height;
		logic [BPP_W-1:0]              bpp;
		logic [CH_W-1:0]               chsel;
		logic                          wide;
		logic [NTAPS-1:0][TAP_W-1:0]   taps;
	} cfg_t;

	// One column step for the window engine.
	typedef struct packed {
		logic             shift;
		logic             pre;
		logic             post;
		logic             first;
		logic             fe;
		logic [PIX_W-1:0] bot;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] top;
	} op_t;

	typedef struct packed {
		logic pend;
	} fst_t;

	typedef struct packed {
		logic [QCNT_W-1:0] cnt;
	} qst_t;

endpackage

// ----- hw/rtl/icrb_if.sv -----
// ----------------------------------------------------------------------------
// icrb interfaces
// Pixel input, pixel output and register write channels.
// ----------------------------------------------------------------------------
interface icrb_in_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [icrb_pkg::PIX_W-1:0]  pixel_in;
	modport source (output valid, output mode, output pixel_in, input ready);
	modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

interface icrb_out_if;
	logic                        valid;
	logic                        ready;
	logic [icrb_pkg::PIX_W-1:0]  pixel_out;
	logic                        frame_end;
	modport source (output valid, output pixel_out, output frame_end, input ready);
	modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

interface icrb_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [icrb_pkg::CFG_IDX_W-1:0]    index;
	logic [icrb_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/icrb_cfg.sv -----
// ----------------------------------------------------------------------------
// icrb_cfg
// Register file; stores effective (clamped) values and flags a restart.
// ----------------------------------------------------------------------------
module icrb_cfg #(
	parameter int MAX_WIDTH = icrb_pkg::MAX_WIDTH_DEF,
	parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	icrb_cfg_if.sink           cfg,
	output logic [WW-1:0]      width,
	output icrb_pkg::cfg_t     regs,
	output logic               restart
);

	logic [WW-1:0]                          width_q;
	logic [icrb_pkg::HEIGHT_W-1:0]          height_q;
	logic [icrb_pkg::BPP_W-1:0]             bpp_q;
	logic [icrb_pkg::CH_W-1:0]              chsel_q;
	logic [icrb_pkg::CFG_DATA_W-1:0]        coef_first_q;
	logic [icrb_pkg::CFG_DATA_W-1:0]        coef_second_q;
	logic [icrb_pkg::TAP_W-1:0]             coef_last_q;
	logic                                   wr;
	logic [icrb_pkg::IMG_W_BITS-1:0]        wv;
	logic [icrb_pkg::BPP_W-1:0]             bv;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid;
	assign wv = cfg.data[icrb_pkg::IMG_W_BITS-1:0];
	assign bv = cfg.data[icrb_pkg::BPP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q       <= WW'(1);
			height_q      <= icrb_pkg::HEIGHT_W'(1);
			bpp_q         <= icrb_pkg::BPP_W'(1);
			chsel_q       <= '0;
			coef_first_q  <= '0;
			coef_second_q <= icrb_pkg::CFG_DATA_W'(4096);
			coef_last_q   <= '0;
		end else if (wr) begin
			case (icrb_pkg::reg_idx_t'(cfg.index))
				icrb_pkg::REG_WIDTH: begin
					if (wv == '0)
						width_q <= WW'(1);
					else if (32'(wv) > MAX_WIDTH)
						width_q <= WW'(MAX_WIDTH);
					else
						width_q <= WW'(wv);
				end
				icrb_pkg::REG_HEIGHT: begin
					if (cfg.data[icrb_pkg::HEIGHT_W-1:0] == '0)
						height_q <= icrb_pkg::HEIGHT_W'(1);
					else
						height_q <= cfg.data[icrb_pkg::HEIGHT_W-1:0];
				end
				icrb_pkg::REG_BPP: begin
					if (bv == '0)
						bpp_q <= icrb_pkg::BPP_W'(1);
					else if (bv > icrb_pkg::BPP_W'(4))
						bpp_q <= icrb_pkg::BPP_W'(4);
					else
						bpp_q <= bv;
				end
				icrb_pkg::REG_CHSEL:       chsel_q <= cfg.data[icrb_pkg::CH_W-1:0];
				icrb_pkg::REG_COEF_FIRST:  coef_first_q <= cfg.data;
				icrb_pkg::REG_COEF_SECOND: coef_second_q <= cfg.data;
				icrb_pkg::REG_COEF_LAST:   coef_last_q <= cfg.data[icrb_pkg::TAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign restart = wr && (cfg.index == icrb_pkg::REG_WIDTH || cfg.index == icrb_pkg::REG_HEIGHT);
	assign width = width_q;

	always_comb begin
		regs.height = height_q;
		regs.bpp    = bpp_q;
		regs.chsel  = chsel_q;
		regs.wide   = (width_q >= WW'(2));
		regs.taps   = {coef_last_q, coef_second_q, coef_first_q};
	end

endmodule

// ----- hw/rtl/icrb_front.sv -----
// ----------------------------------------------------------------------------
// icrb_front
// Tracks raster position, classifies items, keeps the two line buffers and
// issues one column step per beat toward the queue.
// ----------------------------------------------------------------------------
module icrb_front #(
	parameter int MAX_WIDTH = icrb_pkg::MAX_WIDTH_DEF,
	parameter int WW        = $clog2(MAX_WIDTH + 1),
	parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	icrb_in_if.sink            in_stream,
	input  logic [WW-1:0]      width,
	input  icrb_pkg::cfg_t     regs,
	input  logic               restart,
	input  icrb_pkg::qst_t     qst,
	output logic               op_valid,
	output icrb_pkg::op_t      op,
	output icrb_pkg::fst_t     fst
);

	localparam int OCC_W = icrb_pkg::QCNT_W + 1;

	logic [WW-1:0]                 ic_q, oc_q;
	logic [icrb_pkg::ROW_W-1:0]    ir_q;
	logic [icrb_pkg::HEIGHT_W-1:0] orow_q;
	logic                          pend_q;

	logic [icrb_pkg::PIX_W-1:0]    middle_mem [MAX_WIDTH];
	logic [icrb_pkg::PIX_W-1:0]    upper_mem  [MAX_WIDTH];
	logic [icrb_pkg::PIX_W-1:0]    mid_rd, up_rd, fwd_s1, pix_s1;
	logic [AW-1:0]                 idx, idx_s1;
	logic                          wr_s1, byp_s1, v_s1, topmid_s1, virt_s1;
	logic                          shift_s1, pre_s1, post_s1, first_s1, fe_s1;

	logic [OCC_W-1:0]              occ;
	logic                          room, fire_in, region, act, virt, fin, stp, ic0;
	logic                          pre, post, emit, wr, fe;
	logic [icrb_pkg::ROW_W-1:0]    h17;
	logic [WW-1:0]                 ic_nx, oc_nx;

	assign occ  = OCC_W'(qst.cnt) + OCC_W'(v_s1);
	assign room = occ < OCC_W'(icrb_pkg::QDEPTH);
	assign in_stream.ready = !pend_q && room;
	assign fire_in = in_stream.valid && in_stream.ready;

	assign h17    = icrb_pkg::ROW_W'(regs.height);
	assign region = ir_q >= h17;
	// Past the last pixel every beat counts as a drain, whatever its mode.
	assign act    = (pend_q && room) || (fire_in && (region || !in_stream.mode));
	assign virt   = pend_q || region;
	assign fin    = virt && (ir_q > h17);
	assign stp    = !fin;
	assign ic0    = (ic_q == '0);
	assign pre    = fin || (stp && ic0 && ir_q >= icrb_pkg::ROW_W'(2));
	assign post   = stp && !ic0 && (ir_q != '0);
	assign emit   = pre || post;
	assign wr     = act && stp && !virt;
	assign fe     = (oc_q == width - WW'(1)) && (orow_q == regs.height - icrb_pkg::HEIGHT_W'(1));
	assign idx    = ic_q[AW-1:0];
	assign ic_nx  = ic_q + WW'(1);
	assign oc_nx  = oc_q + WW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q   <= '0;
			ir_q   <= '0;
			oc_q   <= '0;
			orow_q <= '0;
			pend_q <= 1'b0;
		end else if (restart) begin
			ic_q   <= '0;
			ir_q   <= '0;
			oc_q   <= '0;
			orow_q <= '0;
			pend_q <= 1'b0;
		end else if (act) begin
			// A virtual step that emits nothing (one-row frames) is followed by
			// an internal step before the next beat is taken.
			pend_q <= virt && stp && !emit;
			if (fin) begin
				ic_q   <= '0;
				ir_q   <= '0;
				oc_q   <= '0;
				orow_q <= '0;
			end else begin
				if (ic_nx >= width) begin
					ic_q <= '0;
					ir_q <= ir_q + icrb_pkg::ROW_W'(1);
				end else begin
					ic_q <= ic_nx;
				end
				if (emit) begin
					if (oc_nx >= width) begin
						oc_q   <= '0;
						orow_q <= orow_q + icrb_pkg::HEIGHT_W'(1);
					end else begin
						oc_q <= oc_nx;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			wr_s1 <= 1'b0;
		end else begin
			v_s1  <= act;
			wr_s1 <= wr;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1    <= idx;
		pix_s1    <= in_stream.pixel_in;
		topmid_s1 <= (ir_q == icrb_pkg::ROW_W'(1));
		virt_s1   <= virt;
		shift_s1  <= stp;
		pre_s1    <= pre;
		post_s1   <= post;
		first_s1  <= (ic_q == WW'(1));
		fe_s1     <= fe;
		// The upper line is written one beat late; forward it on a same-column read.
		byp_s1    <= wr_s1 && (idx_s1 == idx);
		fwd_s1    <= mid_rd;
	end

	always_ff @(posedge clk) begin
		mid_rd <= middle_mem[idx];
		up_rd  <= upper_mem[idx];
		if (wr)
			middle_mem[idx] <= in_stream.pixel_in;
		if (wr_s1)
			upper_mem[idx_s1] <= mid_rd;
	end

	always_comb begin
		op.shift = shift_s1;
		op.pre   = pre_s1;
		op.post  = post_s1;
		op.first = first_s1;
		op.fe    = fe_s1;
		op.mid   = mid_rd;
		op.top   = topmid_s1 ? mid_rd : (byp_s1 ? fwd_s1 : up_rd);
		op.bot   = virt_s1 ? mid_rd : pix_s1;
	end

	assign op_valid = v_s1;
	assign fst.pend = pend_q;

endmodule

// ----- hw/rtl/icrb_fifo.sv -----
// ----------------------------------------------------------------------------
// icrb_fifo
// Short queue of column steps between the front and the window engine.
// ----------------------------------------------------------------------------
module icrb_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  icrb_pkg::op_t      wdata,
	input  logic               pop,
	output logic               rvalid,
	output icrb_pkg::op_t      rdata,
	output icrb_pkg::qst_t     qst
);

	icrb_pkg::op_t                 mem_q [icrb_pkg::QDEPTH];
	logic [icrb_pkg::QADDR_W-1:0]  wp_q, rp_q;
	logic [icrb_pkg::QCNT_W-1:0]   cnt_q;
	logic                          do_pop;

	assign rvalid = (cnt_q != '0);
	assign do_pop = pop && rvalid;
	assign rdata  = mem_q[rp_q];
	assign qst.cnt = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + icrb_pkg::QADDR_W'(1);
			if (do_pop)
				rp_q <= rp_q + icrb_pkg::QADDR_W'(1);
			if (push && !do_pop)
				cnt_q <= cnt_q + icrb_pkg::QCNT_W'(1);
			else if (!push && do_pop)
				cnt_q <= cnt_q - icrb_pkg::QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

endmodule

// ----- hw/rtl/icrb_back.sv -----
// ----------------------------------------------------------------------------
// icrb_back
// Holds the 3x3 window, picks the border-replicated neighborhood, multiplies,
// sums, saturates and presents the result in an output register.
// ----------------------------------------------------------------------------
module icrb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  icrb_pkg::op_t      q_data,
	output logic               pop,
	input  icrb_pkg::cfg_t     regs,
	icrb_out_if.source         out_stream
);

	localparam int PW = icrb_pkg::PIX_W;
	localparam int NT = icrb_pkg::NTAPS;
	localparam int KS = icrb_pkg::KERNEL_SIZE;

	logic [KS-1:0][KS-1:0][PW-1:0]    win_q;   // [slot][row], slot 0 oldest
	logic [KS-1:0][PW-1:0]            col_l, col_c, col_r, col_new;
	logic                             en, do_emit;

	logic                             v_s1, v_s2, v_s3, out_v_q;
	logic [NT-1:0][7:0]               b_s1;
	logic [PW-1:0]                    cw_s1, cw_s2, cw_s3;
	logic                             fe_s1, fe_s2, fe_s3;
	logic signed [icrb_pkg::PROD_W-1:0] a_ext [NT];
	logic signed [icrb_pkg::PROD_W-1:0] t_ext [NT];
	logic signed [icrb_pkg::PROD_W-1:0] prod_s2 [NT];
	logic signed [icrb_pkg::SUM_W-1:0]  rsum_s3 [KS];
	logic signed [icrb_pkg::SUM_W-1:0]  tot;
	logic [7:0]                       val;
	logic [PW-1:0]                    word;
	logic [PW-1:0]                    pix_q;
	logic                             fe_q;

	assign en  = !out_v_q || out_stream.ready;
	assign pop = en && q_valid;
	assign do_emit = pop && (q_data.pre || q_data.post);

	assign col_new = {q_data.bot, q_data.mid, q_data.top};
	assign col_c   = win_q[2];

	// Before the shift: right edge, so the right column repeats the centre.
	// After the shift: left edge when the new column is the second of a row.
	always_comb begin
		if (q_data.pre) begin
			col_l = regs.wide ? win_q[1] : win_q[2];
			col_r = win_q[2];
		end else begin
			col_l = q_data.first ? win_q[2] : win_q[1];
			col_r = col_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (pop && q_data.shift) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= col_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= do_emit;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < KS; r++) begin
				b_s1[r*KS]     <= col_l[r][regs.chsel*8 +: 8];
				b_s1[r*KS + 1] <= col_c[r][regs.chsel*8 +: 8];
				b_s1[r*KS + 2] <= col_r[r][regs.chsel*8 +: 8];
			end
			cw_s1 <= col_c[1];
			fe_s1 <= q_data.fe;
		end
	end

	always_comb begin
		for (int t = 0; t < NT; t++) begin
			a_ext[t] = icrb_pkg::PROD_W'($signed({1'b0, b_s1[t]}));
			t_ext[t] = icrb_pkg::PROD_W'($signed(regs.taps[t]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < NT; t++)
				prod_s2[t] <= a_ext[t] * t_ext[t];
			cw_s2 <= cw_s1;
			fe_s2 <= fe_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < KS; r++)
				rsum_s3[r] <= icrb_pkg::SUM_W'(prod_s2[r*KS])
					+ icrb_pkg::SUM_W'(prod_s2[r*KS + 1])
					+ icrb_pkg::SUM_W'(prod_s2[r*KS + 2]);
			cw_s3 <= cw_s2;
			fe_s3 <= fe_s2;
		end
	end

	// Truncate toward zero only matters for positive sums; negatives clamp to 0.
	always_comb begin
		tot = rsum_s3[0] + rsum_s3[1] + rsum_s3[2];
		if (tot[icrb_pkg::SUM_W-1] || tot == '0)
			val = '0;
		else if (|tot[icrb_pkg::SUM_W-2:20])
			val = 8'hFF;
		else
			val = tot[19:12];
		for (int k = 0; k < 4; k++) begin
			if (icrb_pkg::BPP_W'(k) >= regs.bpp)
				word[k*8 +: 8] = 8'h00;
			else if (icrb_pkg::CH_W'(k) == regs.chsel)
				word[k*8 +: 8] = val;
			else
				word[k*8 +: 8] = cw_s3[k*8 +: 8];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_q <= word;
			fe_q  <= fe_s3;
		end
	end

	assign out_stream.valid     = out_v_q;
	assign out_stream.pixel_out = pix_q;
	assign out_stream.frame_end = fe_q;

endmodule

// ----- hw/rtl/image_correlation_replicate_border.sv -----
// ----------------------------------------------------------------------------
// image_correlation_replicate_border
// Streaming 3x3 correlation of one byte channel with replicated borders.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock and gives one result beat per clock
// in steady state while the output is not stalled. The output for pixel k of
// a frame follows input beat k+width+1 and then passes the line-buffer read
// stage, the queue, and the pick, multiply, sum and output-register stages.
// After the last pixel of a frame, each drain beat flushes one result; in
// one-row frames the first drain beat holds the input while an internal
// column step runs. The rate is set by the two line buffers, each with one
// read and one write port used once per beat. Writing the width or height
// register restarts the frame.
module image_correlation_replicate_border #(
	parameter int MAX_WIDTH = icrb_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	icrb_in_if.sink     in_stream,
	icrb_out_if.source  out_stream,
	icrb_cfg_if.sink    cfg
);

	`include "image_correlation_replicate_border_assert.svh"

	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic [WW-1:0]        width;
	icrb_pkg::cfg_t       regs;
	logic                 restart;
	icrb_pkg::qst_t       qst;
	icrb_pkg::fst_t       fst;
	icrb_pkg::op_t        op, q_data;
	logic                 op_valid, q_valid, pop;

	icrb_cfg #(.MAX_WIDTH(MAX_WIDTH), .WW(WW)) u_cfg (
		.clk, .arst_n, .cfg, .width, .regs, .restart
	);

	icrb_front #(.MAX_WIDTH(MAX_WIDTH), .WW(WW)) u_front (
		.clk, .arst_n, .in_stream, .width, .regs, .restart, .qst,
		.op_valid, .op, .fst
	);

	icrb_fifo u_fifo (
		.clk, .arst_n, .push(op_valid), .wdata(op), .pop,
		.rvalid(q_valid), .rdata(q_data), .qst
	);

	icrb_back u_back (
		.clk, .arst_n, .q_valid, .q_data, .pop, .regs, .out_stream
	);

	`ICRB_ASSERT_IMPL(a_no_overflow, op_valid, qst.cnt != icrb_pkg::QCNT_W'(icrb_pkg::QDEPTH))
	`ICRB_ASSERT_IMPL(a_no_underflow, pop && !q_valid, qst.cnt == '0)
	`ICRB_ASSERT_IMPL(a_pend_blocks, fst.pend, !in_stream.ready)

endmodule
